FILE: src/md4_pkg.sv
// Package for the MD4 hash engine: command codes, front/back queue entry type,
// round constants and step tables. Used by every module under src.
`default_nettype none
package md4_pkg;
   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] K1  = 32'h5a827999;
   localparam logic [31:0] K2  = 32'h6ed9eba1;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // message word used by step i
   function automatic logic [3:0] msg_idx(input logic [5:0] i);
      logic [3:0] j;
      begin
         j = i[3:0];
         case (i[5:4])
            2'd0: msg_idx = j;
            2'd1: msg_idx = {j[1:0], j[3:2]};
            default: msg_idx = {j[0], j[1], j[2], j[3]};
         endcase
      end
   endfunction

   // left rotate amount of step i
   function automatic logic [4:0] rot_amt(input logic [5:0] i);
      logic [3:0] sel;
      begin
         sel = {i[5:4], i[1:0]};
         case (sel)
            4'd0, 4'd4, 4'd8: rot_amt = 5'd3;
            4'd1:  rot_amt = 5'd7;
            4'd2:  rot_amt = 5'd11;
            4'd3:  rot_amt = 5'd19;
            4'd5:  rot_amt = 5'd5;
            4'd6:  rot_amt = 5'd9;
            4'd7:  rot_amt = 5'd13;
            4'd9:  rot_amt = 5'd9;
            4'd10: rot_amt = 5'd11;
            4'd11: rot_amt = 5'd15;
            default: rot_amt = 5'd3;
         endcase
      end
   endfunction
endpackage
`default_nettype wire

FILE: src/md4_queue.sv
// Two-entry queue between the front (request intake) and the back (hash core).
// Depends on md4_pkg.
`default_nettype none
module md4_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire md4_pkg::item_type in_item,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output md4_pkg::item_type     out_item
);
   import md4_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

FILE: src/md4_core.sv
// Back end: block buffer, bit counter, one MD4 step per cycle, padding and
// digest output. Depends on md4_pkg.
`default_nettype none
module md4_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_stall,
   input  wire md4_pkg::item_type item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [31:0]            rsp_digest_word,
   output logic [1:0]             rsp_word_index,
   output logic                   rsp_last
);
   import md4_pkg::*;

   // block buffer as sixteen words, bytes little-endian
   logic [31:0] buf_ff [16];
   logic [31:0] cv_ff  [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] count_ff, count_in;
   logic [5:0]  step_ff, step_in;
   logic        final_ff, final_in;   // this transform ends the message
   logic        second_ff, second_in; // another pad block follows
   logic [1:0]  widx_ff, widx_in;
   state_type   state_ff, state_in;
   logic        take, blk_done, out_fire;
   logic [5:0]  fill;
   logic [31:0] f, kk, sum, t, wsel;
   logic [4:0]  sh;
   logic [63:0] rot2;

   assign fill       = count_ff[8:3];
   assign item_stall = (state_ff != ST_IDLE);
   assign take       = item_valid && (state_ff == ST_IDLE);
   assign out_fire   = rsp_valid && !rsp_stall;
   assign blk_done   = (state_ff == ST_ROUND) && (step_ff == 6'd47);

   // one round step
   always_comb begin
      case (step_ff[5:4])
         2'd0: begin
            f  = (b_ff & c_ff) | (~b_ff & d_ff);
            kk = 32'd0;
         end
         2'd1: begin
            f  = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            kk = K1;
         end
         default: begin
            f  = b_ff ^ c_ff ^ d_ff;
            kk = K2;
         end
      endcase
      wsel = buf_ff[msg_idx(step_ff)];
      sh   = rot_amt(step_ff);
      sum  = a_ff + f + wsel + kk;
      rot2 = {sum, sum} << sh;
      t    = rot2[63:32];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      final_in  = final_ff;
      second_in = second_ff;
      widx_in   = widx_ff;
      count_in  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               step_in = 6'd0;
               if (item.cmd == CMD_ABSORB) begin
                  count_in = count_ff + 64'd8;
                  if (fill == 6'd63) begin
                     state_in = ST_ROUND;
                     final_in = 1'b0;
                  end
               end else begin
                  state_in  = ST_ROUND;
                  second_in = (fill >= 6'd56);
                  final_in  = !(fill >= 6'd56);
               end
            end
         end
         ST_ROUND: begin
            step_in = step_ff + 6'd1;
            if (blk_done) begin
               step_in = 6'd0;
               if (second_ff) begin
                  state_in = ST_PAD;
               end else if (final_ff) begin
                  state_in = ST_EMIT;
                  widx_in  = 2'd0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            state_in  = ST_ROUND;
            second_in = 1'b0;
            final_in  = 1'b1;
         end
         ST_EMIT: begin
            if (out_fire) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  count_in = 64'd0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = cv_ff[widx_ff];
   assign rsp_word_index  = widx_ff;
   assign rsp_last        = (widx_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= 6'd0;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         widx_ff   <= 2'd0;
         count_ff  <= 64'd0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         final_ff  <= final_in;
         second_ff <= second_in;
         widx_ff   <= widx_in;
         count_ff  <= count_in;
      end
   end

   // chaining value: load IV on reset and after the last word, add at block end
   always_ff @(posedge clock) begin
      if (reset || (out_fire && widx_ff == 2'd3)) begin
         cv_ff[0] <= IV0;
         cv_ff[1] <= IV1;
         cv_ff[2] <= IV2;
         cv_ff[3] <= IV3;
      end else if (blk_done) begin
         cv_ff[0] <= cv_ff[0] + d_ff;
         cv_ff[1] <= cv_ff[1] + t;
         cv_ff[2] <= cv_ff[2] + b_ff;
         cv_ff[3] <= cv_ff[3] + c_ff;
      end
   end

   // working variables: seed at block start, rotate each step
   always_ff @(posedge clock) begin
      if ((take && (item.cmd == CMD_FINISH || fill == 6'd63)) ||
          state_ff == ST_PAD) begin
         a_ff <= cv_ff[0];
         b_ff <= cv_ff[1];
         c_ff <= cv_ff[2];
         d_ff <= cv_ff[3];
      end else if (state_ff == ST_ROUND) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= t;
      end
   end

   // buffer writes: data byte, or pad byte plus zeros and length
   always_ff @(posedge clock) begin
      if (take && item.cmd == CMD_ABSORB) begin
         buf_ff[fill[5:2]][fill[1:0]*8 +: 8] <= item.data_byte;
      end else if (take) begin
         // zero the tail, leaving the length bytes to the word writes below
         for (int i = 0; i < 64; i++) begin
            if (i[5:0] == fill) begin
               buf_ff[i[5:2]][i[1:0]*8 +: 8] <= PAD_BYTE;
            end else if (i[5:0] > fill && (i < 56 || fill >= 6'd56)) begin
               buf_ff[i[5:2]][i[1:0]*8 +: 8] <= 8'h00;
            end
         end
         if (fill < 6'd56) begin
            buf_ff[14] <= count_ff[31:0];
            buf_ff[15] <= count_ff[63:32];
         end
      end else if (state_ff == ST_PAD) begin
         for (int i = 0; i < 14; i++) begin
            buf_ff[i[3:0]] <= 32'd0;
         end
         buf_ff[14] <= count_ff[31:0];
         buf_ff[15] <= count_ff[63:32];
      end
   end
endmodule
`default_nettype wire

FILE: src/md4_hash_engine.sv
// MD4 hash engine top level: request queue feeding a one-step-per-cycle core.
// An absorb beat leaves the core idle, but a beat that fills the block holds the
// core for all 48 MD4 steps (one step per cycle); word 0 is valid once the core,
// having taken a finish beat, has run one transform, or two with a second pad block.
// Results: four beats, one per cycle when not stalled. Reset (synchronous)
// loads the initial vector, clears the bit count and empties the queue.
`default_nettype none
module md4_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_last
);
   import md4_pkg::*;

   item_type q_in, q_out;
   logic     q_valid, q_stall;

   // front: pack the request beat
   assign q_in.cmd       = req_cmd;
   assign q_in.data_byte = req_data_byte;

   md4_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_item(q_in),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_out)
   );

   md4_core u_core (
      .clock, .reset,
      .item_valid(q_valid), .item_stall(q_stall), .item(q_out),
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index, .rsp_last
   );

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == 2'd3)))
      else $error("last flag mismatch");
   a_idx_adv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> (rsp_valid &&
       rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("word index skipped");
endmodule
`default_nettype wire

FILE: tb/sv/md4_hash_engine_tb.sv
// Testbench for md4_hash_engine: drives absorb/finish beats and checks digest words.
// Depends on md4_pkg (command codes) and the md4_hash_engine RTL under src.
`timescale 1ns / 100ps
`default_nettype none
module md4_hash_engine_tb;
   import md4_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_beat_type;

   item_type        pending_beats[$];
   digest_beat_type digest_queue[$];
   logic [31:0]     chain[4];
   logic [7:0]      msg_block[64];
   logic [63:0]     msg_bits;
   int              error_count;
   int              mismatch_count;
   bit              quiet_mode;
   bit              stim_done;
   logic            req_fire_ff;

   md4_hash_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // run the 48 MD4 steps over the current block
   task automatic md4_compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, f, k, t;
      int          j, r, m;
      int          shifts[12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};
      for (j = 0; j < 16; j++)
         w[j] = {msg_block[4*j+3], msg_block[4*j+2], msg_block[4*j+1], msg_block[4*j]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (j = 0; j < 48; j++) begin
         r = j >> 4;
         if (r == 0) begin
            f = (b & c) | (~b & d); k = 0; m = j;
         end else if (r == 1) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h5a827999;
            m = ((j & 3) << 2) | ((j >> 2) & 3);
         end else begin
            f = b ^ c ^ d; k = 32'h6ed9eba1;
            m = {j[0], j[1], j[2], j[3]};
         end
         t = rotl(a + f + w[m] + k, shifts[r*4 + (j & 3)]);
         a = d; d = c; c = b; b = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endtask

   task automatic load_iv();
      chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
      msg_bits = '0;
   endtask

   // predict the digest words caused by one accepted beat
   task automatic predict_digest(input item_type it);
      int              fill, j;
      digest_beat_type e;
      fill = int'(msg_bits[8:3]);
      if (it.cmd == CMD_ABSORB) begin
         msg_block[fill] = it.data_byte;
         msg_bits += 8;
         if (fill == 63) md4_compress();
         return;
      end
      msg_block[fill] = 8'h80;
      for (j = fill + 1; j < 64; j++) msg_block[j] = 8'h00;
      if (fill >= 56) begin
         md4_compress();
         for (j = 0; j < 56; j++) msg_block[j] = 8'h00;
      end
      for (j = 0; j < 8; j++) msg_block[56+j] = msg_bits[8*j +: 8];
      md4_compress();
      for (j = 0; j < 4; j++) begin
         e.word = chain[j]; e.index = j[1:0]; e.last = (j == 3);
         digest_queue.push_back(e);
      end
      load_iv();
   endtask

   // note request acceptance at the rising edge
   always @(posedge clock) begin
      req_fire_ff <= !reset && req_valid && !req_stall;
   end

   // driver: present beats at the falling edge, advance on acceptance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire_ff) begin
            predict_digest('{cmd: req_cmd, data_byte: req_data_byte});
            void'(pending_beats.pop_front());
         end
         if (!req_valid || req_fire_ff) begin
            if (pending_beats.size() > 0 && (quiet_mode || $urandom_range(99) >= 17)) begin
               req_valid     <= 1'b1;
               req_cmd       <= pending_beats[0].cmd;
               req_data_byte <= pending_beats[0].data_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 17);
      end
   end

   // monitor: check each accepted digest beat against the oldest expectation
   always @(posedge clock) begin
      digest_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest beat word=%h idx=%0d", rsp_digest_word,
                        rsp_word_index);
         end else begin
            e = digest_queue.pop_front();
            if (rsp_digest_word !== e.word || rsp_word_index !== e.index ||
                rsp_last !== e.last) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", e.word,
                           e.index, e.last, rsp_digest_word, rsp_word_index, rsp_last);
            end
         end
      end
   end

   task automatic add_message(input int len, input bit random_data);
      int j;
      for (j = 0; j < len; j++)
         pending_beats.push_back('{cmd: CMD_ABSORB,
                                   data_byte: random_data ? 8'($urandom) : 8'(j)});
      pending_beats.push_back('{cmd: CMD_FINISH, data_byte: 8'($urandom)});
   endtask

   // stimulus
   initial begin
      int total, len;
      req_valid = 1'b0; req_cmd = CMD_ABSORB; req_data_byte = '0;
      rsp_stall = 1'b0; reset = 1'b1;
      error_count = 0; mismatch_count = 0; quiet_mode = 1'b0; stim_done = 1'b0;
      load_iv();
      foreach (msg_block[j]) msg_block[j] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed: empty message, finish with extreme ignored byte, byte extremes
      pending_beats.push_back('{cmd: CMD_FINISH, data_byte: 8'hff});
      pending_beats.push_back('{cmd: CMD_ABSORB, data_byte: 8'h00});
      pending_beats.push_back('{cmd: CMD_ABSORB, data_byte: 8'hff});
      pending_beats.push_back('{cmd: CMD_ABSORB, data_byte: 8'h55});
      pending_beats.push_back('{cmd: CMD_ABSORB, data_byte: 8'haa});
      pending_beats.push_back('{cmd: CMD_FINISH, data_byte: 8'h00});
      wait (pending_beats.size() == 0);
      // hold off until every digest word is back
      wait (digest_queue.size() == 0);
      // second pad block (56 pending) and the last single-block length
      add_message(56, 1'b0);
      add_message(55, 1'b1);
      // random short messages
      total = 0;
      while (total < 40) begin
         len = $urandom_range(12);
         add_message(len, 1'b1);
         total += len + 1;
      end
      wait (pending_beats.size() == 0);
      // stretch with no idling on either side: a full block, then padding only
      quiet_mode = 1'b1;
      add_message(64, 1'b1);
      wait (pending_beats.size() == 0);
      quiet_mode = 1'b0;
      add_message(5, 1'b1);
      wait (pending_beats.size() == 0);
      wait (digest_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
src/md4_pkg.sv
src/md4_queue.sv
src/md4_core.sv
src/md4_hash_engine.sv
tb/sv/md4_hash_engine_tb.sv
